[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the list store datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/dels_pkg.sv]
// ----------------------------------------------------------------------------
// dels_pkg
// Types and constants shared by the double-ended list store modules.
// ----------------------------------------------------------------------------
package dels_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ELEM_WIDTH = 32;

	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 6;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_READ     = 3'd4
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} stat_e;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [DATA_W-1:0]  element_data;
		logic [INDEX_W-1:0] read_index;
	} cmd_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] element_count;
		logic [DATA_W-1:0]  head_data;
		logic [DATA_W-1:0]  tail_data;
		logic [DATA_W-1:0]  read_data;
	} rsp_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_IDX,
		S_RD_HEAD,
		S_RD_TAIL,
		S_DONE
	} state_e;

	typedef enum logic [1:0] {
		RSEL_IDX,
		RSEL_HEAD,
		RSEL_TAIL
	} rsel_e;

	typedef struct packed {
		logic  latch;
		logic  exec;
		rsel_e rd_sel;
		logic  cap_read;
		logic  cap_head;
		logic  load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

endpackage

[src/dels_ctrl.sv]
// ----------------------------------------------------------------------------
// dels_ctrl
// Sequencer that steps one item through update, three reads and result load.
// ----------------------------------------------------------------------------
module dels_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic                rsp_ready,
	input  dels_pkg::dp_stat_t  stat,
	output dels_pkg::ctrl_cmd_t ctrl
);
	import dels_pkg::*;

	state_e state_q;
	state_e state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_nxt = S_EXEC;
			end
			S_EXEC:    state_nxt = S_RD_IDX;
			S_RD_IDX:  state_nxt = S_RD_HEAD;
			S_RD_HEAD: state_nxt = S_RD_TAIL;
			S_RD_TAIL: state_nxt = S_DONE;
			S_DONE: begin
				if (!stat.out_full || rsp_ready) state_nxt = S_IDLE;
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready     = 1'b0;
		ctrl          = '0;
		ctrl.rd_sel   = RSEL_IDX;
		case (state_q)
			S_IDLE: begin
				cmd_ready  = 1'b1;
				ctrl.latch = cmd_valid;
			end
			S_EXEC: begin
				ctrl.exec = 1'b1;
			end
			S_RD_IDX: begin
				ctrl.rd_sel = RSEL_IDX;
			end
			S_RD_HEAD: begin
				ctrl.rd_sel   = RSEL_HEAD;
				ctrl.cap_read = 1'b1;
			end
			S_RD_TAIL: begin
				ctrl.rd_sel   = RSEL_TAIL;
				ctrl.cap_head = 1'b1;
			end
			S_DONE: begin
				// The tail word stays on the read port while the result waits.
				ctrl.rd_sel   = RSEL_TAIL;
				ctrl.load_out = !stat.out_full || rsp_ready;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/dels_dp.sv]
// ----------------------------------------------------------------------------
// dels_dp
// Circular element memory with head pointer, count and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dels_dp #(
	parameter int CAPACITY   = dels_pkg::DEF_CAPACITY,
	parameter int ELEM_WIDTH = dels_pkg::DEF_ELEM_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dels_pkg::cmd_item_t cmd,
	input  dels_pkg::ctrl_cmd_t ctrl,
	output dels_pkg::dp_stat_t  stat,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dels_pkg::rsp_item_t rsp
);
	import dels_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
	localparam int SW = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;

	logic [SW-1:0] mem [CAPACITY];

	cmd_item_t     cmd_q;
	logic [AW-1:0] hp_q;
	logic [CW-1:0] cnt_q;
	logic [STAT_W-1:0] status_q;
	logic          rd_ok_q;
	logic [SW-1:0] mem_rd_q;
	logic [SW-1:0] rdata_q;
	logic [SW-1:0] head_q;
	rsp_item_t     rsp_q;
	logic          rsp_valid_q;

	logic          is_full;
	logic          is_empty;
	logic          idx_ok;
	logic [AW-1:0] hp_inc;
	logic [AW-1:0] hp_dec;
	logic [AW-1:0] idx_addr;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] append_addr;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [STAT_W-1:0] status_nxt;

	function automatic logic [AW-1:0] wrap(input logic [XW-1:0] s);
		logic [XW-1:0] r;
		r = (s >= XW'(CAPACITY)) ? (s - XW'(CAPACITY)) : s;
		return r[AW-1:0];
	endfunction

	assign is_full     = (cnt_q == CW'(CAPACITY));
	assign is_empty    = (cnt_q == '0);
	assign idx_ok      = (XW'(cmd_q.read_index) < XW'(cnt_q));
	assign hp_inc      = (hp_q == AW'(CAPACITY - 1)) ? '0 : hp_q + 1'b1;
	assign hp_dec      = (hp_q == '0) ? AW'(CAPACITY - 1) : hp_q - 1'b1;
	assign idx_addr    = wrap(XW'(hp_q) + XW'(cmd_q.read_index));
	assign tail_addr   = wrap(XW'(hp_q) + XW'(cnt_q) - XW'(1));
	assign append_addr = wrap(XW'(hp_q) + XW'(cnt_q));

	always_comb begin
		case (ctrl.rd_sel)
			RSEL_IDX:  rd_addr = idx_addr;
			RSEL_HEAD: rd_addr = hp_q;
			RSEL_TAIL: rd_addr = tail_addr;
			default:   rd_addr = hp_q;
		endcase
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = append_addr;
		status_nxt = ST_OK;
		case (cmd_q.command)
			CMD_INS_HEAD: begin
				status_nxt = is_full ? ST_FULL : ST_OK;
				wr_en      = ctrl.exec && !is_full;
				wr_addr    = hp_dec;
			end
			CMD_INS_TAIL: begin
				status_nxt = is_full ? ST_FULL : ST_OK;
				wr_en      = ctrl.exec && !is_full;
				wr_addr    = append_addr;
			end
			CMD_REM_HEAD, CMD_REM_TAIL: begin
				status_nxt = is_empty ? ST_EMPTY : ST_OK;
			end
			CMD_READ: begin
				status_nxt = idx_ok ? ST_OK : ST_RANGE;
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= SW'(cmd_q.element_data);
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) cmd_q <= cmd;
		if (ctrl.exec) begin
			status_q <= status_nxt;
			rd_ok_q  <= (cmd_q.command == CMD_READ) && idx_ok;
		end
		if (ctrl.cap_read) rdata_q <= mem_rd_q;
		if (ctrl.cap_head) head_q <= mem_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q  <= '0;
			cnt_q <= '0;
		end else if (ctrl.exec) begin
			case (cmd_q.command)
				CMD_INS_HEAD: begin
					if (!is_full) begin
						hp_q  <= hp_dec;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CMD_INS_TAIL: begin
					if (!is_full) cnt_q <= cnt_q + 1'b1;
				end
				CMD_REM_HEAD: begin
					if (!is_empty) begin
						hp_q  <= hp_inc;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				CMD_REM_TAIL: begin
					if (!is_empty) cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			rsp_q.status        <= status_q;
			rsp_q.element_count <= COUNT_W'(cnt_q);
			rsp_q.head_data     <= is_empty ? '0 : DATA_W'(head_q);
			rsp_q.tail_data     <= is_empty ? '0 : DATA_W'(mem_rd_q);
			rsp_q.read_data     <= rd_ok_q ? DATA_W'(rdata_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.out_full = rsp_valid_q;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cnt_q <= CW'(CAPACITY), "Count exceeds capacity.")
	`ASSERT_CLK(a_full_status, clk, arst_n, (ctrl.load_out && status_q == ST_FULL) |-> is_full, "Full status with free room.")
	`ASSERT_CLK(a_empty_status, clk, arst_n, (ctrl.load_out && status_q == ST_EMPTY) |-> is_empty, "Empty status with elements held.")
	`ASSERT_NEVER(a_load_overwrite, clk, arst_n, ctrl.load_out && rsp_valid_q && !rsp_ready, "Result overwritten before taken.")

endmodule

[src/double_ended_list_store_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_list_store_unit
// Fixed-capacity double-ended list with indexed read, one result per item.
// ----------------------------------------------------------------------------
// Each item first updates the head pointer, count and memory; then the single
// read port of the element memory fetches the indexed word, the head word and
// the tail word in turn, and last the result register is loaded. The next item
// is accepted only after that. A finished result waits in its own register, so
// the block only holds off when a second result is ready before the first is
// taken.
// No clearing pass follows reset.
module double_ended_list_store_unit #(
	parameter int CAPACITY   = dels_pkg::DEF_CAPACITY,
	parameter int ELEM_WIDTH = dels_pkg::DEF_ELEM_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  dels_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dels_pkg::rsp_item_t rsp
);
	import dels_pkg::*;

	ctrl_cmd_t ctrl;
	dp_stat_t  stat;

	dels_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	dels_dp #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctrl      (ctrl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[test/double_ended_list_store_unit_test.sv]
// ----------------------------------------------------------------------------
// double_ended_list_store_unit_test
// Drives commands into the double-ended list store and checks every result
// against a queue-based mirror of the list. A short directed sequence covers
// the empty, out-of-range and unused-command cases. Random rounds then fill,
// drain and churn the list with random idling on both the command and result
// sides.
// ----------------------------------------------------------------------------
module double_ended_list_store_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dels_pkg::*;

	localparam int          CAPACITY       = DEF_CAPACITY;
	localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
	localparam logic [2:0]  CMD_SPARE_MID  = 3'd6;
	localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
	localparam int          RANDOM_ITEMS   = 1700;
	localparam int          REPORT_LIMIT   = 10;
	localparam int          STALL_LIMIT    = 4000;
	localparam int          DRAIN_CYCLES   = 24;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} round_mode_e;

	class list_mirror;
		logic [DATA_W-1:0] words[$];
		rsp_item_t         owed[$];
		int                results_seen;
		int                failures;
		int                full_rejects;
		int                empty_removes;
		int                range_reads;
		int                peak_depth;

		function void apply_command(cmd_item_t c);
			rsp_item_t r;
			r = '0;
			r.status = ST_OK;
			case (c.command)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (words.size() >= CAPACITY) begin
					r.status = ST_FULL;
					full_rejects++;
				end else if (c.command == CMD_INS_HEAD) begin
					words.push_front(c.element_data);
				end else begin
					words.push_back(c.element_data);
				end
			end
			CMD_REM_HEAD, CMD_REM_TAIL: begin
				if (words.size() == 0) begin
					r.status = ST_EMPTY;
					empty_removes++;
				end else if (c.command == CMD_REM_HEAD) begin
					void'(words.pop_front());
				end else begin
					void'(words.pop_back());
				end
			end
			CMD_READ: begin
				if (c.read_index < words.size()) begin
					r.read_data = words[c.read_index];
				end else begin
					r.status = ST_RANGE;
					range_reads++;
				end
			end
			default: begin
			end
			endcase
			r.element_count = COUNT_W'(words.size());
			if (words.size() != 0) begin
				r.head_data = words[0];
				r.tail_data = words[words.size() - 1];
			end
			if (words.size() > peak_depth)
				peak_depth = words.size();
			owed.push_back(r);
		endfunction

		function void match_result(rsp_item_t got);
			rsp_item_t want;
			results_seen++;
			if (owed.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("ERROR: result %h arrived with nothing pending", got);
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status || got.element_count !== want.element_count ||
					got.head_data !== want.head_data || got.tail_data !== want.tail_data ||
					got.read_data !== want.read_data) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("ERROR: result %0d expected status %0d count %0d %s",
						results_seen, want.status, want.element_count,
						$sformatf("head %h tail %h read %h",
							want.head_data, want.tail_data, want.read_data));
					$display("ERROR: result %0d actual   status %0d count %0d %s",
						results_seen, got.status, got.element_count,
						$sformatf("head %h tail %h read %h",
							got.head_data, got.tail_data, got.read_data));
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	list_mirror shadow = new();
	bit         quiet_round = 1'b0;
	int         sent_items  = 0;

	double_ended_list_store_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic cmd_item_t random_command(round_mode_e mode, int depth);
		cmd_item_t c;
		int        roll;
		int        ins_pct;
		int        idx;
		c.element_data = $urandom;
		if ($urandom_range(0, 15) == 0)
			c.element_data = $urandom_range(0, 1) ? '1 : '0;
		case ($urandom_range(0, 7))
		0: idx = (depth > 0) ? depth - 1 : $urandom_range(0, 63);
		1: idx = (depth < CAPACITY) ? depth : CAPACITY - 1;
		2: idx = $urandom_range(0, 63);
		default: idx = (depth > 0) ? $urandom_range(0, depth - 1) : $urandom_range(0, 63);
		endcase
		c.read_index = INDEX_W'(idx);
		ins_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 10 : 50;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			c.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end else if (roll < 20) begin
			c.command = CMD_READ;
		end else if ($urandom_range(0, 99) < ins_pct) begin
			c.command = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
		end else begin
			c.command = $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
		end
		return c;
	endfunction

	task automatic send_command(cmd_item_t c);
		int gap;
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_ready !== 1'b1);
		shadow.apply_command(c);
		sent_items++;
		gap = quiet_round ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(logic [2:0] op, logic [DATA_W-1:0] data, logic [INDEX_W-1:0] idx);
		cmd_item_t c;
		c.command = op;
		c.element_data = data;
		c.read_index = idx;
		send_command(c);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1)
			shadow.match_result(rsp);
	end

	initial begin : sink
		int hold;
		int gap;
		while (!arst_n)
			@(posedge clk);
		forever begin
			hold = $urandom_range(1, 12);
			rsp_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			gap = quiet_round ? 0 : pick_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
		$display("double_ended_list_store_unit_test: done, errors");
		$finish;
	end

	initial begin : stimulus
		round_mode_e mode;
		int          round_len;
		int          random_sent;
		int          rounds;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: removals are ignored and every read is out of range.
		send_fields(CMD_REM_HEAD, 32'h1234_5678, '0);
		send_fields(CMD_REM_TAIL, '1, '1);
		send_fields(CMD_READ, '0, '0);
		send_fields(CMD_READ, '1, '1);
		send_fields(CMD_SPARE_LO, 32'hDEAD_BEEF, 6'd1);
		send_fields(CMD_SPARE_MID, '1, 6'd2);
		send_fields(CMD_SPARE_HI, '0, 6'd3);
		send_fields(CMD_INS_HEAD, '1, '0);
		send_fields(CMD_INS_TAIL, '0, '1);
		send_fields(CMD_INS_HEAD, 32'hA5A5_5A5A, 6'd21);
		send_fields(CMD_INS_TAIL, 32'h5A5A_A5A5, 6'd42);
		send_fields(CMD_READ, $urandom, 6'd0);
		send_fields(CMD_READ, $urandom, 6'd1);
		send_fields(CMD_READ, $urandom, 6'd3);
		send_fields(CMD_READ, $urandom, 6'd4);
		send_fields(CMD_READ, $urandom, '1);
		send_fields(CMD_SPARE_HI, '1, 6'd0);
		send_fields(CMD_REM_HEAD, $urandom, 6'd0);
		send_fields(CMD_REM_TAIL, $urandom, 6'd0);
		send_fields(CMD_READ, $urandom, 6'd1);
		send_fields(CMD_REM_TAIL, $urandom, 6'd0);
		send_fields(CMD_REM_HEAD, $urandom, 6'd0);
		send_fields(CMD_REM_HEAD, $urandom, 6'd0);
		send_fields(CMD_READ, $urandom, 6'd0);

		random_sent = 0;
		rounds = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (rounds == 0)
				mode = MODE_FILL;
			else if (rounds == 1)
				mode = MODE_DRAIN;
			else
				mode = round_mode_e'($urandom_range(0, 2));
			quiet_round = ($urandom_range(0, 4) == 0);
			round_len = $urandom_range(100, 200);
			repeat (round_len) begin
				send_command(random_command(mode, shadow.words.size()));
				random_sent++;
			end
			rounds++;
		end
		quiet_round = 1'b0;
		cmd_valid <= 1'b0;

		while (shadow.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d commands over %0d random rounds, %0d results checked",
			sent_items, rounds, shadow.results_seen);
		$display("Summary: peak depth %0d, %0d full inserts rejected, %0d empty removes, %0d %s",
			shadow.peak_depth, shadow.full_rejects, shadow.empty_removes,
			shadow.range_reads, "out-of-range reads");
		if (shadow.failures == 0) begin
			$display("double_ended_list_store_unit_test: done, clean");
		end else begin
			$display("ERROR: %0d failing results", shadow.failures);
			$display("double_ended_list_store_unit_test: done, errors");
		end
		$finish;
	end

endmodule
